>>> sv/lru_cache_owner_preferred_evict_assert.svh
// ----------------------------------------------------------------------------
// lru cache assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_OWNER_PREFERRED_EVICT_ASSERT_SVH
`define LRU_CACHE_OWNER_PREFERRED_EVICT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LRUOPE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LRUOPE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lruope_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruope_pkg
// shared constants and types of the owner-preferred lru cache
// ----------------------------------------------------------------------------
package lruope_pkg;

    localparam int MAX_LINES = 8;
    localparam int RANK_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int CFG_W     = 4;
    localparam int BLK_W     = 32;
    localparam int WORD_W    = 32;
    localparam int PID_W     = 8;
    localparam int TOT_W     = 32;

    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(5);

    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        ACT_HIT  = 2'd0,
        ACT_FILL = 2'd1,
        ACT_OWN  = 2'd2,
        ACT_GLOB = 2'd3
    } t_action;

    typedef struct packed {
        logic capture;
        logic look;
        logic update;
    } t_dp_cmd;

endpackage

>>> sv/lruope_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruope_ctrl
// sequencer: accept, tag compare, recency update, result strobe
// ----------------------------------------------------------------------------
module lruope_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output logic                o_done,
    output lruope_pkg::t_dp_cmd o_cmd
);
    import lruope_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK:  n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_UPD);
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.look    = (r_state == S_LOOK);
    assign o_cmd.update  = (r_state == S_UPD);

endmodule

>>> sv/lruope_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruope_dp
// line store, parallel tag compare, victim select and recency update
// ----------------------------------------------------------------------------
module lruope_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lruope_pkg::t_dp_cmd                  i_cmd,
    input  logic                                 i_cfg_wr,
    input  logic [lruope_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [lruope_pkg::BLK_W-1:0]         i_block_number,
    input  logic signed [lruope_pkg::WORD_W-1:0] i_data_value,
    input  logic [lruope_pkg::PID_W-1:0]         i_processor_id,
    output logic                                 o_hit,
    output logic [1:0]                           o_action,
    output logic [lruope_pkg::BLK_W-1:0]         o_victim_block,
    output logic [lruope_pkg::PID_W-1:0]         o_victim_processor,
    output logic [lruope_pkg::TOT_W-1:0]         o_hit_total,
    output logic [lruope_pkg::TOT_W-1:0]         o_miss_total
);
    import lruope_pkg::*;

    // clamp the configured count into 1 .. MAX_LINES
    function automatic t_cnt eff_limit(input logic [CFG_W-1:0] v);
        t_cnt r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > MAX_LINES) begin
            r = CNT_W'(MAX_LINES);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    logic [CFG_W-1:0]         r_lim;
    logic [BLK_W-1:0]         r_blk;
    logic signed [WORD_W-1:0] r_word;
    logic [PID_W-1:0]         r_pid;

    logic [MAX_LINES-1:0]     r_valid;
    logic [BLK_W-1:0]         r_lblk  [MAX_LINES];
    logic signed [WORD_W-1:0] r_lword [MAX_LINES];
    logic [PID_W-1:0]         r_lown  [MAX_LINES];
    t_rank                    r_rank  [MAX_LINES];
    t_cnt                     r_filled;
    logic [TOT_W-1:0]         r_hit_cnt;
    logic [TOT_W-1:0]         r_miss_cnt;

    logic [MAX_LINES-1:0]     r_hit_vec, n_hit_vec;
    logic [MAX_LINES-1:0]     r_own_vec, n_own_vec;

    logic                     r_hit;
    t_action                  r_action;
    logic [BLK_W-1:0]         r_vblk;
    logic [PID_W-1:0]         r_vpid;

    // compare stage
    always_comb begin
        for (int i = 0; i < MAX_LINES; i++) begin
            n_own_vec[i] = r_valid[i] && (r_lown[i] == r_pid);
            n_hit_vec[i] = n_own_vec[i] && (r_lblk[i] == r_blk) && (r_lword[i] == r_word);
        end
    end

    // update stage: pick the slot and the rank it leaves
    logic    hit_any, own_any, fill;
    logic    f_hit, f_empty, f_own, f_glob;
    t_rank   hit_idx, empty_idx, own_idx, glob_idx;
    t_rank   own_best, glob_best;
    t_rank   slot;
    t_cnt    old_rank;
    t_action act;
    logic    evict;

    always_comb begin
        f_hit     = 1'b0;
        f_empty   = 1'b0;
        f_own     = 1'b0;
        f_glob    = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        own_idx   = '0;
        glob_idx  = '0;
        own_best  = '0;
        glob_best = '0;
        for (int i = 0; i < MAX_LINES; i++) begin
            if (!f_hit && r_hit_vec[i]) begin
                hit_idx = RANK_W'(i);
                f_hit   = 1'b1;
            end
            if (!f_empty && !r_valid[i]) begin
                empty_idx = RANK_W'(i);
                f_empty   = 1'b1;
            end
            if (r_own_vec[i] && (!f_own || r_rank[i] > own_best)) begin
                own_idx  = RANK_W'(i);
                own_best = r_rank[i];
                f_own    = 1'b1;
            end
            if (r_valid[i] && (!f_glob || r_rank[i] > glob_best)) begin
                glob_idx  = RANK_W'(i);
                glob_best = r_rank[i];
                f_glob    = 1'b1;
            end
        end
        hit_any = |r_hit_vec;
        own_any = |r_own_vec;
        fill    = (r_filled < eff_limit(r_lim));

        if (hit_any) begin
            slot     = hit_idx;
            old_rank = CNT_W'(r_rank[hit_idx]);
            act      = ACT_HIT;
        end else if (fill) begin
            // every valid line ages when an empty one is filled
            slot     = empty_idx;
            old_rank = r_filled;
            act      = ACT_FILL;
        end else if (own_any) begin
            slot     = own_idx;
            old_rank = CNT_W'(own_best);
            act      = ACT_OWN;
        end else begin
            slot     = glob_idx;
            old_rank = CNT_W'(glob_best);
            act      = ACT_GLOB;
        end
        evict = (act == ACT_OWN) || (act == ACT_GLOB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim      <= LIMIT_RESET;
            r_valid    <= '0;
            r_filled   <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            for (int i = 0; i < MAX_LINES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_lim <= i_cfg_data;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < MAX_LINES; i++) begin
                    if (RANK_W'(i) == slot) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i] && (CNT_W'(r_rank[i]) < old_rank)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                if (act == ACT_FILL) begin
                    r_filled <= r_filled + 1'b1;
                end
                if (hit_any) begin
                    if (r_hit_cnt != '1) begin
                        r_hit_cnt <= r_hit_cnt + 1'b1;
                    end
                end else if (r_miss_cnt != '1) begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_blk  <= i_block_number;
            r_word <= i_data_value;
            r_pid  <= i_processor_id;
        end
        if (i_cmd.look) begin
            r_hit_vec <= n_hit_vec;
            r_own_vec <= n_own_vec;
        end
        if (i_cmd.update) begin
            if (!hit_any) begin
                r_lblk[slot]  <= r_blk;
                r_lword[slot] <= r_word;
                r_lown[slot]  <= r_pid;
            end
            r_hit    <= hit_any;
            r_action <= act;
            r_vblk   <= evict ? r_lblk[slot] : '0;
            r_vpid   <= evict ? r_lown[slot] : '0;
        end
    end

    assign o_hit              = r_hit;
    assign o_action           = r_action;
    assign o_victim_block     = r_vblk;
    assign o_victim_processor = r_vpid;
    assign o_hit_total        = r_hit_cnt;
    assign o_miss_total       = r_miss_cnt;

endmodule

>>> sv/lru_cache_owner_preferred_evict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_owner_preferred_evict
// fully associative lru cache, eviction prefers the requester's own lines
//
// channel   direction  handshake                    payload
// access    in         start & !busy                block_number, data_value,
//                                                   processor_id
// result    out        o_done, one-cycle strobe     hit, action, victim_*, totals
// config    in         i_cfg_valid & o_cfg_ready    lines_in_use
//
// each access raises its strobe after the LOOK and UPD states: tag compare over all
// lines in parallel, then victim select and recency update
// a new access is taken in the cycle its predecessor's result is shown, so
// no access is taken while its predecessor is in the compare/update sequence
// synchronous active-low reset empties all lines, clears counters, limit 5
// the result strobe cannot be stalled; config is always ready
// ----------------------------------------------------------------------------
module lru_cache_owner_preferred_evict (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lruope_pkg::BLK_W-1:0]         i_block_number,
    input  logic signed [lruope_pkg::WORD_W-1:0] i_data_value,
    input  logic [lruope_pkg::PID_W-1:0]         i_processor_id,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lruope_pkg::CFG_W-1:0]         i_cfg_lines_in_use,
    output logic                                 o_done,
    output logic                                 o_hit,
    output logic [1:0]                           o_action,
    output logic [lruope_pkg::BLK_W-1:0]         o_victim_block,
    output logic [lruope_pkg::PID_W-1:0]         o_victim_processor,
    output logic [lruope_pkg::TOT_W-1:0]         o_hit_total,
    output logic [lruope_pkg::TOT_W-1:0]         o_miss_total
);
    import lruope_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    lruope_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    lruope_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg_wr           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_lines_in_use),
        .i_block_number     (i_block_number),
        .i_data_value       (i_data_value),
        .i_processor_id     (i_processor_id),
        .o_hit              (o_hit),
        .o_action           (o_action),
        .o_victim_block     (o_victim_block),
        .o_victim_processor (o_victim_processor),
        .o_hit_total        (o_hit_total),
        .o_miss_total       (o_miss_total)
    );

endmodule

>>> sv/lruope_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruope_chk
// port-level checker for the lru cache, bound to the top level
// ----------------------------------------------------------------------------
`include "lru_cache_owner_preferred_evict_assert.svh"

module lruope_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_hit,
    input logic [1:0] o_action,
    input logic [lruope_pkg::BLK_W-1:0] o_victim_block,
    input logic [lruope_pkg::PID_W-1:0] o_victim_processor
);
    import lruope_pkg::*;

    logic access_taken;
    logic hit_agrees;
    logic no_evict;
    logic victim_clear;

    assign access_taken = start && !busy;
    assign hit_agrees   = (o_hit == (o_action == ACT_HIT));
    assign no_evict     = o_done && (o_action == ACT_HIT || o_action == ACT_FILL);
    assign victim_clear = (o_victim_block == '0) && (o_victim_processor == '0);

    // an accepted access holds the block busy next cycle
    `LRUOPE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, access_taken, busy, "not busy after accept")

    // the result strobe rises after the look and update states that follow accept
    `LRUOPE_ASSERT_NXT(a_accept_done, i_clk, i_rst_n, access_taken, ##2 o_done, "strobe missing")

    // result shows while the block is free again
    `LRUOPE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "busy during result")

    // hit flag and action code agree
    `LRUOPE_ASSERT_IMP(a_hit_action, i_clk, i_rst_n, o_done, hit_agrees, "hit and action disagree")

    // no victim reported unless a line was evicted
    `LRUOPE_ASSERT_IMP(a_no_victim, i_clk, i_rst_n, no_evict, victim_clear, "victim without eviction")

endmodule

bind lru_cache_owner_preferred_evict lruope_chk u_lruope_chk (.*);
